// ===== design/catmull_rom_ribbon_tessellator_defines.svh =====
// Assertion macros for the ribbon tessellator
`ifndef CATMULL_ROM_RIBBON_TESSELLATOR_DEFINES_SVH
`define CATMULL_ROM_RIBBON_TESSELLATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define CRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tessellator assertion failed");
`define CRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tessellator assertion failed");
`else
`define CRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/crt_pkg.sv =====
package crt_pkg;

    localparam int SEGMENT_SAMPLES_DEF = 50;
    localparam int NUM_COORDS          = 6;
    localparam int COORD_W             = 32;
    localparam int AGE_W               = 24;
    localparam int TEX_W               = 17;
    localparam int IN_DATA_W           = 216;
    localparam int OUT_DATA_W          = 216;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic [TEX_W-1:0] TEX_ONE     = 17'd65536;
    localparam logic [AGE_W-1:0] INV_LIFE_RST = 24'd65536;

    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic REG_INV_LIFE_TIME = 1'b0;

    typedef struct packed {
        logic [NUM_COORDS-1:0][COORD_W-1:0] c;
        logic [AGE_W-1:0]                   age;
    } point_t;

endpackage

// ===== design/catmull_rom_ribbon_tessellator.sv =====
// A push of the first or second point of a trail only fills the window and gives no result.
// A segment gives SEGMENT_SAMPLES results; each sample takes 6 coordinate passes of
// Horner steps, a clamp and, unless saturated, byte-wise divide rounds, then tex_v and an emit.
// A new point is taken only once the segment's last result is emitted; the samples use a shared
// multiply-add unit and the byte-wise reciprocal divide unit.
// Reset: synchronous, active low; clears the trail, sets inv_life_time to 1.0.
`include "catmull_rom_ribbon_tessellator_defines.svh"

module catmull_rom_ribbon_tessellator
    import crt_pkg::*;
#(
    parameter int SEGMENT_SAMPLES = SEGMENT_SAMPLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // root_x, root_y, root_z, tip_x, tip_y, tip_z, point_age
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_root_x, out_root_y, out_root_z, out_tip_x, out_tip_y, out_tip_z, tex_v, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int JW = (SEGMENT_SAMPLES > 2) ? $clog2(SEGMENT_SAMPLES) : 1;
    localparam int NW = $clog2(SEGMENT_SAMPLES + 1);
    localparam int LW = AGE_W + NW;
    localparam longint N_L  = longint'(SEGMENT_SAMPLES);
    localparam longint N2_L = N_L * N_L;
    localparam longint N3_L = N2_L * N_L;
    localparam longint D_L  = 2 * N3_L;
    localparam longint DV_L = N_L * 65536;
    localparam int DW = $clog2(DV_L + 1);
    localparam int XW = COORD_W + DW;
    // coordinate divide: remainder below D, one quotient byte per round
    localparam int DCW = $clog2(D_L);
    localparam int YW  = DCW + 8;
    localparam int QW  = DCW + 32;
    localparam int CS  = YW + DCW;
    // tex_v divide: (tprod >> 16) / N in one reciprocal multiply
    localparam int TL  = $clog2(SEGMENT_SAMPLES);
    localparam int TYW = 16 + TL;
    localparam int TS  = TYW + TL;
    localparam longint MC_L = ((longint'(1) << CS) + D_L - 1) / D_L;
    localparam longint MT_L = ((longint'(1) << TS) + N_L - 1) / N_L;
    localparam logic signed [63:0] N_S     = 64'(N_L);
    localparam logic signed [63:0] N2_S    = 64'(N2_L);
    localparam logic signed [63:0] N3_S    = 64'(N3_L);
    localparam logic signed [63:0] LIM_S   = 64'(D_L) <<< 31;
    localparam logic [63:0]        TSAT_U  = 64'(DV_L) << 16;
    localparam logic [YW-1:0]      D_Y     = YW'(D_L);
    localparam logic [31:0]        MC_M    = 32'(MC_L);
    localparam logic [31:0]        MT_M    = 32'(MT_L);
    localparam logic [JW-1:0]      J_LAST  = JW'(SEGMENT_SAMPLES - 1);
    localparam logic [2:0]         K_LAST  = 3'(NUM_COORDS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_H1, S_H2, S_H3, S_CLAMP, S_DIV, S_REM, S_T1, S_T2, S_T3, S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [1:0]             seen_reg;
    point_t [2:0]           win_reg;
    point_t                 np_reg;
    logic                   lead_reg, trail_reg, fin_reg;
    logic [JW-1:0]          j_reg;
    logic [2:0]             k_reg;
    logic signed [63:0]     acc_reg;
    logic [LW-1:0]          lerp_reg;
    logic [XW-1:0]          tprod_reg;
    logic [DCW-1:0]         rem_reg;
    logic [31:0]            quo_reg;
    logic [YW-1:0]          y_reg;
    logic [7:0]             qd_reg;
    logic [1:0]             cnt_reg;
    logic [NUM_COORDS-1:0][COORD_W-1:0] res_reg;
    logic [TEX_W-1:0]       tex_reg;
    logic [23:0]            inv_reg;
    logic                   m_valid_reg, m_last_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    point_t                 np_in;
    logic signed [33:0]     w0, w1, w2, wn, pa, pb, pc, pd;
    logic signed [39:0]     ea, eb, ec, ed, coef_a, coef_b, coef_c;
    logic signed [63:0]     j_s, mul_op, term, mac;
    logic [AGE_W-1:0]       age1, age2;
    logic [63:0]            lerp_full, tprod_full;
    logic [31:0]            mul_y, mul_m;
    logic [63:0]            rprod;
    logic [7:0]             qd_calc;
    logic [TEX_W-1:0]       tex_q;
    logic                   out_free, cfg_wr;

    assign np_in.c   = s_tdata[NUM_COORDS*COORD_W-1:0];
    assign np_in.age = s_tdata[NUM_COORDS*COORD_W +: AGE_W];

    assign w0 = 34'($signed(win_reg[0].c[k_reg]));
    assign w1 = 34'($signed(win_reg[1].c[k_reg]));
    assign w2 = 34'($signed(win_reg[2].c[k_reg]));
    assign wn = 34'($signed(np_reg.c[k_reg]));

    always_comb begin
        pa = lead_reg ? (2 * w0 - w1) : w0;
        pb = lead_reg ? w0 : w1;
        pc = lead_reg ? w1 : w2;
        pd = trail_reg ? (2 * pc - pb) : wn;
        ea = 40'(pa);
        eb = 40'(pb);
        ec = 40'(pc);
        ed = 40'(pd);
        coef_a = ec - ea;
        coef_b = 2 * ea - 5 * eb + 4 * ec - ed;
        coef_c = 3 * eb - 3 * ec + ed - ea;
    end

    // Horner step: acc*j + term (coef_c*j + term in the first step)
    assign j_s    = $signed(64'(j_reg));
    assign mul_op = (state_reg == S_H1) ? 64'(coef_c) : acc_reg;
    always_comb begin
        case (state_reg)
            S_H1:    term = 64'(coef_b) * N_S;
            S_H2:    term = 64'(coef_a) * N2_S;
            default: term = (64'(eb) * 2 + 64'sd1) * N3_S;
        endcase
    end
    assign mac = mul_op * j_s;

    assign age1 = lead_reg ? win_reg[0].age : win_reg[1].age;
    assign age2 = lead_reg ? win_reg[1].age : win_reg[2].age;
    assign lerp_full  = 64'(age1) * (64'(SEGMENT_SAMPLES) - 64'(j_reg)) + 64'(age2) * 64'(j_reg);
    assign tprod_full = 64'(lerp_reg) * 64'(inv_reg);

    // shared reciprocal multiply, exact quotient for the operand ranges used
    assign mul_y   = (state_reg == S_T3) ? 32'(tprod_reg[TYW+15:16])
                                         : 32'({rem_reg, quo_reg[31:24]});
    assign mul_m   = (state_reg == S_T3) ? MT_M : MC_M;
    assign rprod   = 64'(mul_y) * 64'(mul_m);
    assign qd_calc = 8'(rprod >> CS);
    assign tex_q   = TEX_W'(rprod >> TS);

    assign out_free = !m_valid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            seen_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
            inv_reg     <= INV_LIFE_RST;
            k_reg       <= 3'd0;
        end else begin
            if (cfg_wr && paddr[2] == REG_INV_LIFE_TIME) begin
                inv_reg <= pwdata[23:0];
            end
            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        np_reg <= np_in;
                        j_reg  <= '0;
                        k_reg  <= 3'd0;
                        if (s_tuser == CMD_FINISH) begin
                            if (seen_reg[1]) begin
                                lead_reg  <= (seen_reg == 2'd2);
                                trail_reg <= 1'b1;
                                fin_reg   <= 1'b1;
                                state_reg <= S_H1;
                            end else begin
                                seen_reg <= 2'd0;
                            end
                        end else if (!seen_reg[1]) begin
                            win_reg[seen_reg] <= np_in;
                            seen_reg          <= seen_reg + 2'd1;
                        end else begin
                            lead_reg  <= (seen_reg == 2'd2);
                            trail_reg <= 1'b0;
                            fin_reg   <= 1'b0;
                            state_reg <= S_H1;
                        end
                    end
                end
                S_H1: begin
                    acc_reg   <= mac + term;
                    state_reg <= S_H2;
                end
                S_H2: begin
                    acc_reg   <= mac + term;
                    state_reg <= S_H3;
                end
                S_H3: begin
                    acc_reg   <= mac + term;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (acc_reg >= LIM_S || acc_reg < -LIM_S) begin
                        res_reg[k_reg] <= acc_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        if (k_reg == K_LAST) begin
                            state_reg <= S_T1;
                        end else begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= S_H1;
                        end
                    end else begin
                        {rem_reg, quo_reg} <= QW'(acc_reg + LIM_S);
                        cnt_reg            <= 2'd0;
                        state_reg          <= S_DIV;
                    end
                end
                S_DIV: begin
                    y_reg     <= {rem_reg, quo_reg[31:24]};
                    qd_reg    <= qd_calc;
                    state_reg <= S_REM;
                end
                S_REM: begin
                    rem_reg <= DCW'(y_reg - YW'(qd_reg) * D_Y);
                    quo_reg <= {quo_reg[23:0], qd_reg};
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        res_reg[k_reg] <= {quo_reg[23:0], qd_reg} ^ 32'h8000_0000;
                        if (k_reg == K_LAST) begin
                            state_reg <= S_T1;
                        end else begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= S_H1;
                        end
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_T1: begin
                    lerp_reg  <= LW'(lerp_full);
                    state_reg <= S_T2;
                end
                S_T2: begin
                    tprod_reg <= XW'(tprod_full);
                    state_reg <= S_T3;
                end
                S_T3: begin
                    if (64'(tprod_reg) >= TSAT_U) begin
                        tex_reg <= TEX_ONE;
                    end else begin
                        tex_reg <= tex_q;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_last_reg  <= (j_reg == J_LAST);
                        m_data_reg  <= {7'd0, tex_reg, res_reg};
                        k_reg       <= 3'd0;
                        if (j_reg == J_LAST) begin
                            state_reg <= S_IDLE;
                            if (fin_reg) begin
                                seen_reg <= 2'd0;
                            end else if (lead_reg) begin
                                win_reg[2] <= np_reg;
                                seen_reg   <= 2'd3;
                            end else begin
                                win_reg[0] <= win_reg[1];
                                win_reg[1] <= win_reg[2];
                                win_reg[2] <= np_reg;
                            end
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_H1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_INV_LIFE_TIME) ? {8'd0, inv_reg} : '0;

    `CRT_ASSERT_NEXT(a_seg_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == CMD_PUSH && seen_reg[1], state_reg != S_IDLE)
    `CRT_ASSERT_NEXT(a_short_finish, aclk, aresetn, s_tvalid && s_tready && s_tuser == CMD_FINISH && !seen_reg[1], seen_reg == 2'd0)
    `CRT_ASSERT_IMPL(a_tex_range, aclk, aresetn, state_reg == S_EMIT, tex_reg <= TEX_ONE)
    `CRT_ASSERT_IMPL(a_coord_idx, aclk, aresetn, state_reg != S_IDLE, k_reg <= K_LAST)

endmodule
